// File: rtl/pel_pkg.sv
// Package: widths, pipeline constants and elaboration-time tables for the pixel corrector.
`timescale 1ns / 1ps
package pel_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned ProdW   = 24;  // channel * gain
  localparam int unsigned FracW   = 24;  // log2 fraction bits
  localparam int unsigned LogW    = 29;  // 5 integer + 24 fraction bits
  localparam int unsigned MantW   = 31;  // Q1.30 mantissa / Q0.30 power
  localparam int unsigned TW      = 33;  // scaled log after gamma multiply
  localparam int unsigned ShW     = 4;   // right shift 0..8
  localparam int unsigned FullScale = 1044480;  // 255 * 4096
  localparam int unsigned GainReset = 4096;
  localparam int unsigned IgamReset = 4096;
  localparam int unsigned DarkShift = 9;

  // Lane depth: product, normalize, 24 squarings, subtract, gamma multiply,
  // 24 exponent factors, byte rounding.
  localparam int unsigned LaneLat = 2 + FracW + 2 + FracW + 1;

  localparam logic [CfgIdxW-1:0] RegExposureGain = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegInverseGamma = CfgIdxW'(1);

  typedef enum logic [1:0] {
    OVR_NONE = 2'd0,
    OVR_ZERO = 2'd1,
    OVR_FULL = 2'd2
  } ovr_e;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = v;
    root = 64'd0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > rem) bitv = bitv >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 64'd0) begin
        if (rem >= root + bitv) begin
          rem  = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return root;
  endfunction

  // Q0.30 factor 2^(-2^-i), i from 1
  function automatic logic [MantW-1:0] exp_factor(input int unsigned i);
    logic [63:0] r;
    r = isqrt64(64'd1 << 59);
    for (int j = 1; j < 32; j++) begin
      if (j < i) r = isqrt64(r << 30);
    end
    return r[MantW-1:0];
  endfunction

  function automatic logic [LogW-1:0] log2_q24(input logic [ProdW-1:0] p);
    int unsigned k;
    logic [63:0] m;
    logic [LogW-1:0] res;
    k = 0;
    for (int j = 0; j < ProdW; j++) begin
      if (p[j]) k = j;
    end
    m = ({40'd0, p} << 30) >> k;
    res = LogW'(k) << FracW;
    for (int i = FracW - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  localparam logic [LogW-1:0] LogFull = log2_q24(ProdW'(FullScale));

endpackage

// File: rtl/pel_pix_in_if.sv
// Interface: input pixel channel with valid/ready handshake.
`timescale 1ns / 1ps
interface pel_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// File: rtl/pel_pix_out_if.sv
// Interface: output pixel channel with valid/ready handshake.
`timescale 1ns / 1ps
interface pel_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// File: rtl/pixel_exposure_gamma_correct.sv
// Top level: config registers, three color lanes, alpha delay line and output merge.
//
//   channel   dir  handshake        payload
//   pix_i     in   valid/ready      red_in, green_in, blue_in, alpha_in
//   pix_o     out  valid/ready      red_out, green_out, blue_out, alpha_out
//   cfg       in   cfg_we_i only    cfg_idx_i, cfg_data_i
//
// One pixel per clock while pix_o is not stalled; each transaction passes
// through the per-lane log2 and exp2 chains (24 steps each) before it
// leaves. Reset clears the valid bits and loads gain and inverse gamma to 1.0.
// The whole pipeline advances when the output stage is empty or taken, so a
// stall on pix_o holds every stage and drops ready on pix_i.
`timescale 1ns / 1ps
module pixel_exposure_gamma_correct (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pel_pix_in_if.sink                   pix_i,
  pel_pix_out_if.source                pix_o,
  input  logic                         cfg_we_i,
  input  logic [pel_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pel_pkg::CfgW-1:0]     cfg_data_i
);
  import pel_pkg::*;

  logic [CfgW-1:0]  gain_q;
  logic [CfgW-1:0]  igam_q;
  logic [LaneLat-1:0] vld_q;
  logic [ByteW-1:0] alpha_q [0:LaneLat-1];
  logic             adv;
  logic [ByteW-1:0] red_w, green_w, blue_w;

  // advance when the output slot is free or being taken
  assign adv         = !vld_q[LaneLat-1] || pix_o.ready;
  assign pix_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= CfgW'(GainReset);
      igam_q <= CfgW'(IgamReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegExposureGain: gain_q <= cfg_data_i;
        RegInverseGamma: igam_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LaneLat-2:0], pix_i.valid};
    end
  end

  // alpha rides alongside the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      alpha_q[0] <= pix_i.alpha_in;
      for (int i = 1; i < LaneLat; i++) alpha_q[i] <= alpha_q[i-1];
    end
  end

  pel_lane u_red (
    .clk_i (clk_i), .en_i (adv), .chan_i (pix_i.red_in),
    .gain_i (gain_q), .igam_i (igam_q), .chan_o (red_w)
  );
  pel_lane u_green (
    .clk_i (clk_i), .en_i (adv), .chan_i (pix_i.green_in),
    .gain_i (gain_q), .igam_i (igam_q), .chan_o (green_w)
  );
  pel_lane u_blue (
    .clk_i (clk_i), .en_i (adv), .chan_i (pix_i.blue_in),
    .gain_i (gain_q), .igam_i (igam_q), .chan_o (blue_w)
  );

  // merge lane results with the delayed alpha
  assign pix_o.valid     = vld_q[LaneLat-1];
  assign pix_o.red_out   = red_w;
  assign pix_o.green_out = green_w;
  assign pix_o.blue_out  = blue_w;
  assign pix_o.alpha_out = alpha_q[LaneLat-1];

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.ready == (!pix_o.valid || pix_o.ready))
    else $error("input ready does not follow output slot");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_ripple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[LaneLat-2] |=> vld_q[LaneLat-1])
    else $error("transaction lost before output stage");

endmodule

// File: rtl/pel_lane.sv
// One color lane: exposure product, log2, gamma scaling, exp2 and byte rounding.
`timescale 1ns / 1ps
module pel_lane (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [pel_pkg::ByteW-1:0] chan_i,
  input  logic [pel_pkg::CfgW-1:0]  gain_i,
  input  logic [pel_pkg::CfgW-1:0]  igam_i,
  output logic [pel_pkg::ByteW-1:0] chan_o
);
  import pel_pkg::*;

  localparam int unsigned NSt = FracW;

  logic [ProdW-1:0] p_q;
  logic [MantW-1:0] m_q   [0:NSt];
  logic [LogW-1:0]  res_q [0:NSt];
  ovr_e             lov_q [0:NSt];
  logic [LogW-1:0]  dl_q;
  ovr_e             dov_q;
  logic [MantW-1:0] y_q   [0:NSt];
  logic [FracW-1:0] f_q   [0:NSt];
  logic [ShW-1:0]   n_q   [0:NSt];
  ovr_e             eov_q [0:NSt];
  logic [ByteW-1:0] byte_q;

  // exposure product
  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= ProdW'(chan_i) * ProdW'(gain_i);
  end

  // normalize to Q1.30, flag zero and saturation
  logic [4:0]       k_d;
  logic [MantW-1:0] m0_d;
  ovr_e             ov0_d;
  always_comb begin
    k_d = 5'd0;
    for (int j = 0; j < ProdW; j++) begin
      if (p_q[j]) k_d = 5'(j);
    end
    m0_d = MantW'(({30'd0, p_q} << 30) >> k_d);
    if (p_q == '0) ov0_d = OVR_ZERO;
    else if (p_q >= ProdW'(FullScale)) ov0_d = OVR_FULL;
    else ov0_d = OVR_NONE;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]   <= m0_d;
      res_q[0] <= LogW'(k_d) << FracW;
      lov_q[0] <= ov0_d;
    end
  end

  // one log2 fraction bit per stage
  for (genvar s = 0; s < NSt; s++) begin : g_log
    logic [61:0] sq;
    logic [31:0] sqh;
    assign sq  = 62'(m_q[s]) * 62'(m_q[s]);
    assign sqh = sq[61:30];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[s+1]   <= sqh[31] ? sqh[31:1] : sqh[30:0];
        res_q[s+1] <= res_q[s] | (LogW'(sqh[31]) << (FracW - 1 - s));
        lov_q[s+1] <= lov_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_q  <= LogFull - res_q[NSt];
      dov_q <= lov_q[NSt];
    end
  end

  // scale by inverse gamma
  logic [44:0] tp;
  logic [TW-1:0] t_d;
  assign tp  = 45'(dl_q) * 45'(igam_i);
  assign t_d = tp[44:12];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[0] <= MantW'(1) << 30;
      f_q[0] <= t_d[FracW-1:0];
      n_q[0] <= t_d[ShW-1+FracW:FracW];
      if (dov_q == OVR_NONE && t_d[TW-1:FracW] >= (TW-FracW)'(DarkShift))
        eov_q[0] <= OVR_ZERO;
      else eov_q[0] <= dov_q;
    end
  end

  // one exp2 factor per stage
  for (genvar s = 0; s < NSt; s++) begin : g_exp
    localparam logic [MantW-1:0] Fac = exp_factor(s + 1);
    logic [61:0] yp;
    assign yp = 62'(y_q[s]) * 62'(Fac);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[s+1]   <= f_q[s][FracW-1-s] ? yp[60:30] : y_q[s];
        f_q[s+1]   <= f_q[s];
        n_q[s+1]   <= n_q[s];
        eov_q[s+1] <= eov_q[s];
      end
    end
  end

  // shift, scale to a byte and round
  logic [MantW-1:0] ys;
  logic [39:0]      bsum;
  logic [ByteW-1:0] byte_d;
  always_comb begin
    ys   = y_q[NSt] >> n_q[NSt];
    bsum = 40'(ys) * 40'd255 + (40'd1 << 29);
    unique case (eov_q[NSt])
      OVR_NONE: byte_d = (bsum[39:30] > 10'd255) ? 8'hFF : bsum[37:30];
      OVR_ZERO: byte_d = '0;
      OVR_FULL: byte_d = 8'hFF;
      default:  byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) byte_q <= byte_d;
  end

  assign chan_o = byte_q;

endmodule

// File: bench/testbench.sv
// Testbench for pixel_exposure_gamma_correct: per-channel checks against a bit-exact predictor.
`timescale 1ns / 1ps
module testbench;
  import pel_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  localparam int unsigned SettleCycles = 64;  // pipeline depth plus margin
  localparam int unsigned LongHold     = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  pel_pix_in_if  pix_i ();
  pel_pix_out_if pix_o ();

  pixel_exposure_gamma_correct dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .pix_o     (pix_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Predictor copy of the two registers.
  logic [15:0] gain_q;
  logic [15:0] igam_q;
  logic [63:0] exp_rom [1:24];  // Q0.30 factors 2^(-2^-i)
  logic [63:0] log_full;

  pixel_t corrected_q[$];
  int unsigned fail_count;
  bit no_idle;
  int unsigned hold_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem  = v;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // log2 in Q.24 by repeated squaring of a Q1.30 mantissa.
  function automatic logic [63:0] log2_fix(input logic [23:0] p);
    int k;
    logic [63:0] m;
    logic [63:0] acc;
    k = 0;
    for (int j = 0; j < 24; j++) if (p[j]) k = j;
    m   = ({40'd0, p} << 30) >> k;
    acc = 64'(k) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        acc[i] = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic logic [7:0] correct_channel(input logic [7:0] c);
    logic [31:0] p;
    logic [63:0] t;
    logic [63:0] y;
    logic [31:0] n;
    p = c * gain_q;
    if (p == 0) return 8'd0;
    if (p >= FullScale) return 8'd255;
    t = ((log_full - log2_fix(p[23:0])) * igam_q) >> 12;
    n = 32'(t >> 24);
    if (n >= DarkShift) return 8'd0;
    y = 64'd1 << 30;
    for (int i = 1; i <= 24; i++) if (t[24-i]) y = (y * exp_rom[i]) >> 30;
    y = y >> n;
    y = (y * 255 + (64'd1 << 29)) >> 30;
    return (y > 255) ? 8'd255 : y[7:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one pixel, hold it until taken, then idle for a random gap.
  task automatic send_pixel(input pixel_t px);
    pixel_t exp_px;
    int unsigned gap;
    pix_i.valid    <= 1'b1;
    pix_i.red_in   <= px.red;
    pix_i.green_in <= px.green;
    pix_i.blue_in  <= px.blue;
    pix_i.alpha_in <= px.alpha;
    @(posedge clk_i);
    while (!pix_i.ready) @(posedge clk_i);
    exp_px.red   = correct_channel(px.red);
    exp_px.green = correct_channel(px.green);
    exp_px.blue  = correct_channel(px.blue);
    exp_px.alpha = px.alpha;
    corrected_q.push_back(exp_px);
    gap = pick_gap();
    if (gap > 0) begin
      pix_i.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_rgba(input int r, input int g, input int b, input int a);
    send_pixel({8'(r), 8'(g), 8'(b), 8'(a)});
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 8));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_reg();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'd4096;
      4: return 16'($urandom_range(1024, 12288));
      default: return 16'($urandom);
    endcase
  endfunction

  // Wait out every outstanding transaction, then let the pipeline settle.
  task automatic drain();
    pix_i.valid <= 1'b0;
    @(posedge clk_i);
    while (corrected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegExposureGain) gain_q = val;
    else if (idx == RegInverseGamma) igam_q = val;
    @(posedge clk_i);
  endtask

  // Receiver: check each transaction and throttle ready.
  initial begin
    int unsigned stall_left;
    int unsigned hold_seen;
    pixel_t got;
    pixel_t want;
    int unsigned r;
    stall_left = 0;
    hold_seen  = 0;
    pix_o.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pix_o.valid && pix_o.ready) begin
        got = {pix_o.red_out, pix_o.green_out, pix_o.blue_out, pix_o.alpha_out};
        if (corrected_q.size() == 0) begin
          $display("%0t: unexpected pixel %h", $time, got);
          fail_count++;
        end else begin
          want = corrected_q.pop_front();
          if (got.red !== want.red)
            $display("%0t: red expected %0d got %0d", $time, want.red, got.red);
          if (got.green !== want.green)
            $display("%0t: green expected %0d got %0d", $time, want.green, got.green);
          if (got.blue !== want.blue)
            $display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
          if (got.alpha !== want.alpha)
            $display("%0t: alpha expected %0d got %0d", $time, want.alpha, got.alpha);
          if (got !== want) fail_count++;
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        stall_left--;
        pix_o.ready <= 1'b0;
      end else if (no_idle) begin
        pix_o.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 14) pix_o.ready <= 1'b1;
        else begin
          pix_o.ready <= 1'b0;
          stall_left = (r < 19) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
      end
    end
  end

  // Reset values: identity curve, so bytes pass through.
  task automatic test_reset_values();
    send_rgba(0, 255, 1, 0);
    send_rgba(255, 0, 128, 255);
    send_rgba(127, 128, 254, 170);
    send_rgba(85, 170, 85, 85);
    drain();
  endtask

  // Extremes of both registers and the special cases.
  task automatic test_special_cases();
    write_reg(RegExposureGain, 16'd0);           // zero after exposure
    send_rgba(255, 128, 1, 7);
    drain();
    write_reg(RegExposureGain, 16'hFFFF);        // saturation
    write_reg(RegInverseGamma, 16'd1);
    send_rgba(1, 16, 255, 9);
    drain();
    write_reg(RegExposureGain, 16'd1);           // very dark result
    write_reg(RegInverseGamma, 16'hFFFF);
    send_rgba(1, 255, 200, 33);
    drain();
    write_reg(RegExposureGain, 16'd4096);        // inverse gamma zero
    write_reg(RegInverseGamma, 16'd0);
    send_rgba(1, 0, 100, 66);
    drain();
    write_reg(RegInverseGamma, 16'd1862);        // typical 1/2.2
    write_reg(CfgIdxW'(2), 16'd0);               // out-of-range indexes: drop
    write_reg(CfgIdxW'(255), 16'hFFFF);
    send_rgba(1, 64, 254, 255);
    send_rgba(255, 0, 2, 128);
    drain();
  endtask

  // Random pixels over a series of random register settings.
  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegExposureGain, (ph == 0) ? 16'hFFFF : rand_reg());
      write_reg(RegInverseGamma, (ph == 1) ? 16'd1 : rand_reg());
      no_idle = (ph == 3);
      for (int k = 0; k < 150; k++)
        send_pixel({rand_byte(), rand_byte(), rand_byte(), rand_byte()});
      drain();
    end
    no_idle = 1'b0;
  endtask

  // Hold off the output long enough that the input stalls.
  task automatic test_backpressure();
    write_reg(RegExposureGain, 16'd6000);
    write_reg(RegInverseGamma, 16'd1862);
    no_idle  = 1'b1;
    hold_req = hold_req + 1;
    for (int k = 0; k < 150; k++)
      send_pixel({rand_byte(), rand_byte(), rand_byte(), rand_byte()});
    no_idle = 1'b0;
    drain();
  endtask

  // Pause the sender until everything comes back, then resume.
  task automatic test_sender_pause();
    for (int rep = 0; rep < 4; rep++) begin
      for (int k = 0; k < 20; k++)
        send_pixel({rand_byte(), rand_byte(), rand_byte(), rand_byte()});
      pix_i.valid <= 1'b0;
      @(posedge clk_i);
      while (corrected_q.size() != 0) @(posedge clk_i);
    end
    drain();
  endtask

  initial begin
    logic [63:0] r;
    fail_count  = 0;
    no_idle     = 1'b0;
    hold_req    = 0;
    gain_q      = 16'(GainReset);
    igam_q      = 16'(IgamReset);
    r = int_sqrt(64'd1 << 59);
    for (int i = 1; i <= 24; i++) begin
      exp_rom[i] = r;
      r = int_sqrt(r << 30);
    end
    log_full = log2_fix(24'(FullScale));
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    pix_i.valid    <= 1'b0;
    pix_i.red_in   <= '0;
    pix_i.green_in <= '0;
    pix_i.blue_in  <= '0;
    pix_i.alpha_in <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_special_cases();
    test_random_phases();
    test_backpressure();
    test_sender_pause();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pel_pkg.sv
rtl/pel_pix_in_if.sv
rtl/pel_pix_out_if.sv
rtl/pel_lane.sv
rtl/pixel_exposure_gamma_correct.sv
bench/testbench.sv
